FILE: rtl/core/lspf_pkg.sv
package lspf_pkg;

  localparam int unsigned DEF_MAX_DEGREE = 2;
  localparam int unsigned DEF_MAX_POINTS = 32;
  localparam int unsigned DEF_COORD_BITS = 10;
  localparam logic [63:0] INT64_MAX_C = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN_C = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_Q16 = 64'h0000_0000_0001_0000;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
  } md_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] q;
  } md_rsp_t;

  function automatic logic [63:0] sat_sub64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] d;
    begin
      d = a - b;
      if (a[63] != b[63] && d[63] != a[63]) begin
        sat_sub64 = a[63] ? INT64_MIN_C : INT64_MAX_C;
      end else begin
        sat_sub64 = d;
      end
    end
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] to_q16(input logic [63:0] s);
    to_q16 = (s > (INT64_MAX_C >> 16)) ? INT64_MAX_C : {s[47:0], 16'd0};
  endfunction

endpackage

FILE: rtl/core/lspf_muldiv.sv
module lspf_muldiv
  import lspf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} md_state_t;

  md_state_t    state_r;
  logic [63:0]  ma_r, mb_r, mc_r;
  logic         neg_r, zero_r;
  logic [127:0] prod_r;
  logic [1:0]   mcnt_r;
  logic [6:0]   bcnt_r;
  logic [64:0]  rem_r;
  logic [127:0] quo_r;
  logic [63:0]  q_r;
  logic         done_r;

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [64:0]  rsh;
  logic [63:0]  limit;

  always_comb begin
    pa = mcnt_r[1] ? ma_r[63:32] : ma_r[31:0];
    pb = mcnt_r[0] ? mb_r[63:32] : mb_r[31:0];
    pp = pa * pb;
    rsh = {rem_r[63:0], prod_r[127]};
    limit = neg_r ? INT64_MIN_C : INT64_MAX_C;
  end

  always_ff @(posedge clk) begin
    done_r <= rst_n && (state_r == S_FIN);
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            ma_r <= mag64(req.a);
            mb_r <= mag64(req.b);
            mc_r <= mag64(req.c);
            neg_r <= req.a[63] ^ req.b[63] ^ req.c[63];
            zero_r <= (req.a == 64'd0) || (req.b == 64'd0) || (req.c == 64'd0);
            prod_r <= '0;
            mcnt_r <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= prod_r + ({64'd0, pp} << ({5'd0, mcnt_r[1]} * 7'd32
                    + {5'd0, mcnt_r[0]} * 7'd32));
          mcnt_r <= mcnt_r + 2'd1;
          if (mcnt_r == 2'd3) begin
            state_r <= S_DIV;
            bcnt_r <= '0;
            rem_r <= '0;
            quo_r <= '0;
          end
        end
        S_DIV: begin
          if (bcnt_r == 7'd0 && quo_r == 128'd0 && rem_r[64] == 1'b0 && mcnt_r == 2'd0) begin
            prod_r <= prod_r + {65'd0, mc_r[63:1]};
            mcnt_r <= 2'd1;
          end else begin
            prod_r <= {prod_r[126:0], 1'b0};
            if (rsh >= {1'b0, mc_r}) begin
              rem_r <= rsh - {1'b0, mc_r};
              quo_r <= {quo_r[126:0], 1'b1};
            end else begin
              rem_r <= rsh;
              quo_r <= {quo_r[126:0], 1'b0};
            end
            bcnt_r <= bcnt_r + 7'd1;
            if (bcnt_r == 7'd127) begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (zero_r) begin
            q_r <= '0;
          end else if (quo_r[127:64] != 64'd0 || quo_r[63:0] > limit) begin
            q_r <= limit;
          end else begin
            q_r <= neg_r ? (64'd0 - quo_r[63:0]) : quo_r[63:0];
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.busy = (state_r != S_IDLE);
  assign rsp.done = done_r;
  assign rsp.q = q_r;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == S_IDLE) else $error("muldiv start while busy");
  a_done_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == S_FIN) |-> done_r) else $error("muldiv done missing");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("muldiv done not a pulse");
`endif

endmodule

FILE: rtl/core/least_squares_poly_fit.sv
// Least-squares polynomial fit of degree 1 or 2, chosen by the degree register.
// Each transfer on the in_ channel brings one point. Points are summed into
// saturating power and moment sums with two multipliers, one power per
// cycle, and a new point is taken only once the last one is summed. Points
// past MAX_POINTS in a set are dropped and flagged.
// A transfer with in_last_point set starts the solve: Gaussian elimination
// with partial pivoting and back substitution, in Q16 fixed point. Each
// multiply-divide a*b/c runs in one shared unit: the request is issued and
// registered, the unit starts, multiplies in 32-bit partial products, adds
// half the divisor to round, divides bit by bit, finishes with saturation
// and then signals done. A quadratic solve needs 17 of them, a linear one
// needs 7. Results then leave lowest power first, one per transfer, with
// out_last_coef on the highest.
// in_stall is high whenever the block is busy with a point, a solve or results.
// When out_stall is high the current result holds and no new point is taken.
// Reset clears the sums and sets the degree register to two.
// The degree register may only be written while the block is idle.
module least_squares_poly_fit
  import lspf_pkg::*;
#(
  parameter int unsigned MAX_DEGREE = DEF_MAX_DEGREE,
  parameter int unsigned MAX_POINTS = DEF_MAX_POINTS,
  parameter int unsigned COORD_BITS = DEF_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  in_point_x,
  input  logic [9:0]  in_point_y,
  input  logic        in_last_point,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_coefficient,
  output logic [1:0]  out_coef_index,
  output logic        out_last_coef,
  output logic        out_singular,
  output logic        out_points_dropped
);

  localparam int unsigned NSYS = MAX_DEGREE + 1;
  localparam int unsigned NPOW = 2 * MAX_DEGREE + 1;
  localparam int unsigned IW = $clog2(NSYS + 1);
  localparam int unsigned PW = $clog2(NPOW + 1);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ACC, S_LOAD, S_PIV, S_SWAP, S_ELIM, S_EWAIT, S_CHK,
    S_BINIT, S_BSUB, S_BWAIT, S_BDIV, S_BDWAIT, S_OUT
  } state_t;

  state_t      state_r;
  logic [1:0]  deg_r;
  logic [63:0] psum_r [NPOW];
  logic [63:0] msum_r [NSYS];
  logic [CW-1:0] cnt_r;
  logic        ovf_r;
  logic [63:0] mat_r [NSYS][NSYS];
  logic [63:0] rhs_r [NSYS];
  logic [63:0] sol_r [NSYS];
  logic [COORD_BITS-1:0] x_r, y_r;
  logic        last_r, take_r;
  logic [63:0] pw_r;
  logic [PW-1:0] pi_r;
  logic [IW-1:0] n_r, k_r, i_r, j_r, r_r;
  logic [63:0] best_r, acc_r;
  logic        sing_r;
  logic [IW-1:0] oi_r;
  md_req_t     md_req;
  md_rsp_t     md_rsp;
  logic [1:0]  deg_eff;
  logic [63:0] ymul, pmul, addp, addm;
  logic [127:0] ym_full, pm_full;

  lspf_muldiv u_md (.clk(clk), .rst_n(rst_n), .req(md_req), .rsp(md_rsp));

  always_comb begin
    deg_eff = (deg_r == 2'd0) ? 2'd1 : deg_r;
    if (32'(deg_eff) > MAX_DEGREE) deg_eff = 2'(MAX_DEGREE);
    ym_full = {{(64-COORD_BITS){1'b0}}, y_r} * pw_r;
    pm_full = {{(64-COORD_BITS){1'b0}}, x_r} * pw_r;
    ymul = (ym_full[127:64] != 64'd0) ? '1 : ym_full[63:0];
    pmul = (pm_full[127:64] != 64'd0) ? '1 : pm_full[63:0];
    addp = psum_r[pi_r] + pw_r;
    if (addp < pw_r) addp = '1;
    addm = '0;
    if (32'(pi_r) < NSYS) begin
      addm = msum_r[pi_r[IW-1:0]] + ymul;
      if (addm < ymul) addm = '1;
    end
  end

  always_ff @(posedge clk) begin
    md_req.start <= rst_n && (state_r == S_ELIM || state_r == S_BINIT || state_r == S_BSUB);
    if (!rst_n) begin
      state_r <= S_IDLE;
      deg_r <= 2'd2;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      out_valid <= 1'b0;
      for (int p = 0; p < NPOW; p++) psum_r[p] <= '0;
      for (int p = 0; p < NSYS; p++) msum_r[p] <= '0;
    end else begin
      if (cfg_we) deg_r <= cfg_wdata;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            x_r <= in_point_x[COORD_BITS-1:0];
            y_r <= in_point_y[COORD_BITS-1:0];
            last_r <= in_last_point;
            take_r <= (32'(cnt_r) < MAX_POINTS);
            if (32'(cnt_r) >= MAX_POINTS) ovf_r <= 1'b1;
            pw_r <= 64'd1;
            pi_r <= '0;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (take_r) begin
            psum_r[pi_r] <= addp;
            if (32'(pi_r) < NSYS) msum_r[pi_r[IW-1:0]] <= addm;
            pw_r <= pmul;
          end
          pi_r <= pi_r + 1'b1;
          if (32'(pi_r) == NPOW - 1 || !take_r) begin
            if (take_r) cnt_r <= cnt_r + 1'b1;
            n_r <= IW'(deg_eff) + 1'b1;
            state_r <= last_r ? S_LOAD : S_IDLE;
          end
        end
        S_LOAD: begin
          for (int a = 0; a < NSYS; a++) begin
            for (int b = 0; b < NSYS; b++) mat_r[a][b] <= to_q16(psum_r[a+b]);
            rhs_r[a] <= to_q16(msum_r[a]);
            sol_r[a] <= '0;
          end
          sing_r <= 1'b0;
          k_r <= '0;
          i_r <= IW'(1);
          r_r <= '0;
          best_r <= mag64(to_q16(psum_r[0]));
          state_r <= (n_r == IW'(1)) ? S_CHK : S_PIV;
        end
        S_PIV: begin
          if (i_r < n_r) begin
            if (mag64(mat_r[i_r][k_r]) > best_r) begin
              best_r <= mag64(mat_r[i_r][k_r]);
              r_r <= i_r;
            end
            i_r <= i_r + 1'b1;
          end else begin
            state_r <= (best_r == 64'd0) ? S_CHK : S_SWAP;
            if (best_r == 64'd0) sing_r <= 1'b1;
          end
        end
        S_SWAP: begin
          if (r_r != k_r) begin
            for (int b = 0; b < NSYS; b++) begin
              mat_r[k_r][b] <= mat_r[r_r][b];
              mat_r[r_r][b] <= mat_r[k_r][b];
            end
            rhs_r[k_r] <= rhs_r[r_r];
            rhs_r[r_r] <= rhs_r[k_r];
          end
          i_r <= k_r + 1'b1;
          j_r <= k_r + 1'b1;
          state_r <= S_ELIM;
        end
        S_ELIM: begin
          md_req.a <= mat_r[i_r][k_r];
          md_req.b <= (j_r == n_r) ? rhs_r[k_r] : mat_r[k_r][j_r];
          md_req.c <= mat_r[k_r][k_r];
          state_r <= S_EWAIT;
        end
        S_EWAIT: begin
          if (md_rsp.done) begin
            if (j_r == n_r) begin
              rhs_r[i_r] <= sat_sub64(rhs_r[i_r], md_rsp.q);
              mat_r[i_r][k_r] <= '0;
              if (i_r == n_r - 1'b1) begin
                if (k_r == n_r - IW'(2)) begin
                  state_r <= S_CHK;
                end else begin
                  k_r <= k_r + 1'b1;
                  r_r <= k_r + 1'b1;
                  best_r <= mag64(mat_r[k_r+1'b1][k_r+1'b1]);
                  i_r <= k_r + IW'(2);
                  state_r <= S_PIV;
                end
              end else begin
                i_r <= i_r + 1'b1;
                j_r <= k_r + 1'b1;
                state_r <= S_ELIM;
              end
            end else begin
              mat_r[i_r][j_r] <= sat_sub64(mat_r[i_r][j_r], md_rsp.q);
              j_r <= j_r + 1'b1;
              state_r <= S_ELIM;
            end
          end
        end
        S_CHK: begin
          if (sing_r || mat_r[n_r-1'b1][n_r-1'b1] == 64'd0) begin
            sing_r <= 1'b1;
            oi_r <= '0;
            state_r <= S_OUT;
          end else begin
            i_r <= n_r - 1'b1;
            state_r <= S_BINIT;
          end
        end
        S_BINIT: begin
          md_req.a <= rhs_r[i_r];
          md_req.b <= ONE_Q16;
          md_req.c <= 64'd1;
          j_r <= i_r + 1'b1;
          state_r <= S_BWAIT;
        end
        S_BWAIT: begin
          if (md_rsp.done) begin
            acc_r <= md_rsp.q;
            state_r <= S_BSUB;
          end
        end
        S_BSUB: begin
          if (j_r < n_r) begin
            md_req.a <= mat_r[i_r][j_r];
            md_req.b <= sol_r[j_r];
            md_req.c <= ONE_Q16;
            state_r <= S_BDWAIT;
          end else begin
            md_req.a <= acc_r;
            md_req.b <= ONE_Q16;
            md_req.c <= mat_r[i_r][i_r];
            j_r <= '1;
            state_r <= S_BDWAIT;
          end
        end
        S_BDWAIT: begin
          if (md_rsp.done) begin
            if (j_r == '1) begin
              sol_r[i_r] <= md_rsp.q;
              if (i_r == '0) begin
                oi_r <= '0;
                state_r <= S_OUT;
              end else begin
                i_r <= i_r - 1'b1;
                state_r <= S_BINIT;
              end
            end else begin
              acc_r <= sat_sub64(acc_r, md_rsp.q);
              j_r <= j_r + 1'b1;
              state_r <= S_BSUB;
            end
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_coefficient <= sing_r ? 64'd0 : sol_r[oi_r];
            out_coef_index <= oi_r[1:0];
            out_last_coef <= (oi_r == n_r - 1'b1);
            out_singular <= sing_r;
            out_points_dropped <= ovf_r;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            if (oi_r == n_r - 1'b1) begin
              for (int p = 0; p < NPOW; p++) psum_r[p] <= '0;
              for (int p = 0; p < NSYS; p++) msum_r[p] <= '0;
              cnt_r <= '0;
              ovf_r <= 1'b0;
              state_r <= S_IDLE;
            end else begin
              oi_r <= oi_r + 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);

`ifndef SYNTHESIS
  a_out_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("result outside output phase");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= MAX_POINTS) else $error("point count overrun");
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_coefficient == 64'd0) else $error("singular nonzero");
  a_md_idle: assert property (@(posedge clk) disable iff (!rst_n)
    md_rsp.busy |-> state_r == S_EWAIT || state_r == S_BWAIT || state_r == S_BDWAIT)
    else $error("divider busy out of wait");
`endif

endmodule
